// ===== design/memory_map_with_io_ports_macros.svh =====
// assertion macros for the memory map block
// needs clk_i and rst_ni in the scope where they are used
`ifndef MEMORY_MAP_WITH_IO_PORTS_MACROS_SVH
`define MEMORY_MAP_WITH_IO_PORTS_MACROS_SVH

// same-cycle implication, off while in reset
`define MMIO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define MMIO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mmio_pkg.sv =====
// shared types and constants of the memory map block
// no dependencies
package mmio_pkg;

  // default sizes
  localparam int unsigned ROM_BYTES_DEF  = 8192;
  localparam int unsigned RAM_BYTES_DEF  = 4096;
  localparam int unsigned KEY_ROWS_DEF   = 9;

  // video ram is fixed by the map
  localparam int unsigned VRAM_BYTES = 1024;
  localparam int unsigned VRAM_AW    = $clog2(VRAM_BYTES);

  // address map
  localparam logic [15:0] MAP_RAM_BASE  = 16'h2000;
  localparam logic [15:0] MAP_IO_LOW    = 16'h3000;
  localparam logic [15:0] MAP_KEY_BASE  = 16'h3800;
  localparam logic [15:0] MAP_VRAM_BASE = 16'h4000;
  localparam logic [15:0] MAP_VRAM_END  = 16'h4400;
  localparam logic [15:0] MAP_PORT      = 16'h6000;

  localparam logic [7:0] TAPE_HIGH_CODE = 8'hf9;
  localparam logic [7:0] TAPE_LOW_CODE  = 8'h0a;
  localparam logic [7:0] OPEN_BUS       = 8'hff;
  localparam logic [7:0] ROM_FILL       = 8'hff;

  typedef enum logic [2:0] {
    REQ_READ     = 3'd0,
    REQ_WRITE    = 3'd1,
    REQ_ROM_LOAD = 3'd2,
    REQ_KEY_ROW  = 3'd3,
    REQ_PORT_SIG = 3'd4
  } req_e;

  // what travels from the access stage to the output register
  typedef struct packed {
    logic       from_mem;
    logic [7:0] rd_byte;
    logic       tape_valid;
    logic       tape_level;
  } stage_t;

endpackage

// ===== design/mmio_ram.sv =====
// generic single-port synchronous ram, registered read data
// no dependencies; read data holds until the next read
module mmio_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/memory_map_with_io_ports.sv =====
// bus-side memory map: rom, ram and video ram in one ram, key rows and port in flops
// depends on mmio_pkg, mmio_ram and memory_map_with_io_ports_macros.svh
//
//   channel | dir | tuser        | tdata
//   s_axis  | in  | req_type     | addr, data, signal_mask, key_row, key_pressed
//   m_axis  | out | -            | read_data, tape_out_valid, tape_out_level
//
// one item per cycle unless clearing or stalled; a result goes through the ram read and the output register
// after reset a clearing pass writes all ROM_BYTES+RAM_BYTES+VRAM_BYTES entries (13312 by default),
// one ram entry a cycle, with s_axis_tready_o low
// a stalled output holds the access stage, and s_axis_tready_o drops once both are full
// writes land at the beat, so a later read always sees them
module memory_map_with_io_ports #(
  parameter int unsigned ROM_BYTES = mmio_pkg::ROM_BYTES_DEF,
  parameter int unsigned RAM_BYTES = mmio_pkg::RAM_BYTES_DEF,
  parameter int unsigned KEY_ROWS  = mmio_pkg::KEY_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // addr[15:0], data[23:16], signal_mask[31:24], key_row[35:32], key_pressed[43:36], zero
  input  logic [47:0] s_axis_tdata_i,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_data[7:0], tape_out_valid[8], tape_out_level[9], zero
  output logic [15:0] m_axis_tdata_o
);

  localparam int unsigned MEM_DEPTH = ROM_BYTES + RAM_BYTES + mmio_pkg::VRAM_BYTES;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
  localparam int unsigned KEY_AW    = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;

  localparam logic [MEM_AW-1:0] RAM_BASE  = MEM_AW'(ROM_BYTES);
  localparam logic [MEM_AW-1:0] VRAM_BASE = MEM_AW'(ROM_BYTES + RAM_BYTES);
  localparam logic [MEM_AW-1:0] CLR_LAST  = MEM_AW'(MEM_DEPTH - 1);

  // input fields
  logic [15:0] in_addr;
  logic [7:0]  in_data;
  logic [7:0]  in_mask;
  logic [3:0]  in_row;
  logic [7:0]  in_keys;
  mmio_pkg::req_e in_req;

  assign in_addr = s_axis_tdata_i[15:0];
  assign in_data = s_axis_tdata_i[23:16];
  assign in_mask = s_axis_tdata_i[31:24];
  assign in_row  = s_axis_tdata_i[35:32];
  assign in_keys = s_axis_tdata_i[43:36];
  assign in_req  = mmio_pkg::req_e'(s_axis_tuser_i);

  // state
  logic              clearing_q;
  logic [MEM_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [7:0]        key_rows_q [KEY_ROWS];
  logic [7:0]        port_q, port_d;
  logic              s1_valid_q;
  mmio_pkg::stage_t  s1_q, s1_d;
  logic              out_valid_q;
  logic [15:0]       out_q;

  logic in_acc, s1_adv;
  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !clearing_q && (!s1_valid_q || s1_adv);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // decode
  logic              item_re, item_we, key_we;
  logic [MEM_AW-1:0] item_addr;
  logic [15:0]       ram_off, key_off;
  logic              in_rom, in_ram, in_vram, ram_ok, rom_ok, key_hit;

  assign ram_off = in_addr - mmio_pkg::MAP_RAM_BASE;
  assign key_off = in_addr - mmio_pkg::MAP_KEY_BASE;
  assign in_rom  = in_addr < mmio_pkg::MAP_RAM_BASE;
  assign in_ram  = !in_rom && (in_addr < mmio_pkg::MAP_IO_LOW);
  assign in_vram = (in_addr >= mmio_pkg::MAP_VRAM_BASE) && (in_addr < mmio_pkg::MAP_VRAM_END);
  assign rom_ok  = {1'b0, in_addr} < 17'(ROM_BYTES);
  assign ram_ok  = ram_off < 16'(RAM_BYTES);
  assign key_hit = (in_addr >= mmio_pkg::MAP_KEY_BASE) && (key_off < 16'(KEY_ROWS));

  logic [MEM_AW-1:0] ram_addr, vram_addr;
  assign ram_addr  = RAM_BASE + MEM_AW'(ram_off);
  assign vram_addr = VRAM_BASE + MEM_AW'(in_addr[mmio_pkg::VRAM_AW-1:0]);

  always_comb begin
    item_re   = 1'b0;
    item_we   = 1'b0;
    key_we    = 1'b0;
    item_addr = MEM_AW'(in_addr);
    port_d    = port_q;
    s1_d      = '0;
    unique case (in_req)
      mmio_pkg::REQ_READ: begin
        if (in_rom) begin
          item_re       = rom_ok;
          s1_d.from_mem = rom_ok;
          s1_d.rd_byte  = mmio_pkg::OPEN_BUS;
        end else if (in_ram) begin
          item_re       = ram_ok;
          item_addr     = ram_addr;
          s1_d.from_mem = ram_ok;
          s1_d.rd_byte  = mmio_pkg::OPEN_BUS;
        end else if (in_vram) begin
          item_re       = 1'b1;
          item_addr     = vram_addr;
          s1_d.from_mem = 1'b1;
        end else if (key_hit) begin
          s1_d.rd_byte = ~key_rows_q[key_off[KEY_AW-1:0]];
        end else if (in_addr == mmio_pkg::MAP_PORT) begin
          s1_d.rd_byte = port_q;
        end else begin
          s1_d.rd_byte = mmio_pkg::OPEN_BUS;
        end
      end
      mmio_pkg::REQ_WRITE: begin
        if (in_ram) begin
          item_we   = ram_ok;
          item_addr = ram_addr;
        end else if (in_vram) begin
          item_we   = 1'b1;
          item_addr = vram_addr;
        end else if (in_addr == mmio_pkg::MAP_PORT) begin
          if (in_data == mmio_pkg::TAPE_HIGH_CODE) begin
            s1_d.tape_valid = 1'b1;
            s1_d.tape_level = 1'b1;
          end else if (in_data == mmio_pkg::TAPE_LOW_CODE) begin
            s1_d.tape_valid = 1'b1;
          end
        end
      end
      mmio_pkg::REQ_ROM_LOAD: begin
        item_we = rom_ok;
      end
      mmio_pkg::REQ_KEY_ROW: begin
        key_we = {1'b0, in_row} < 5'(KEY_ROWS);
      end
      mmio_pkg::REQ_PORT_SIG: begin
        if ((in_data & in_mask) != 8'h00) begin
          port_d = port_q | in_mask;
        end else begin
          port_d = port_q & ~in_mask;
        end
      end
      default: begin
      end
    endcase
  end

  // ram port: clearing pass, else the accepted beat
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_addr;
  logic [7:0]        mem_wdata, mem_rdata;

  always_comb begin
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_re    = 1'b0;
      mem_addr  = clr_cnt_q;
      mem_wdata = (clr_cnt_q < RAM_BASE) ? mmio_pkg::ROM_FILL : 8'h00;
    end else begin
      mem_we    = in_acc && item_we;
      mem_re    = in_acc && item_re;
      mem_addr  = item_addr;
      mem_wdata = in_data;
    end
  end

  assign clr_cnt_d = clr_cnt_q + MEM_AW'(1);

  mmio_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // control and side-band state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      port_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < KEY_ROWS; i++) begin
        key_rows_q[i] <= '0;
      end
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_d;
        if (clr_cnt_q == CLR_LAST) begin
          clearing_q <= 1'b0;
        end
      end
      if (in_acc) begin
        port_q <= port_d;
        if (key_we) begin
          key_rows_q[in_row[KEY_AW-1:0]] <= in_keys;
        end
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q <= {6'b0, s1_q.tape_level, s1_q.tape_valid,
                s1_q.from_mem ? mem_rdata : s1_q.rd_byte};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

`include "memory_map_with_io_ports_macros.svh"

  `MMIO_ASSERT_NOW(a_no_beat_clearing, clearing_q, !s_axis_tready_o, "beat taken during clearing pass")
  `MMIO_ASSERT_NOW(a_ram_one_access, 1'b1, !(mem_we && mem_re), "ram read and write in one cycle")
  `MMIO_ASSERT_NEXT(a_beat_enters_stage, in_acc, s1_valid_q, "accepted beat lost before stage")
  `MMIO_ASSERT_NOW(a_tape_level_gated, out_valid_q && !out_q[8], !out_q[9], "tape level without valid")

endmodule

// ===== sim/memory_map_checker.sv =====
// checker for the memory map block: watches both stream channels, keeps its own copy
// of rom, ram, video ram, key rows and system port, and compares every result beat
// depends on mmio_pkg
module memory_map_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // addr[15:0], data[23:16], signal_mask[31:24], key_row[35:32], key_pressed[43:36], zero
  input  logic [47:0] s_axis_tdata_i,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // read_data[7:0], tape_out_valid[8], tape_out_level[9], zero
  input  logic [15:0] m_axis_tdata_i,
  output int          fails_o,
  output int          pending_o,
  output int          compared_o,
  output int          tape_hits_o
);
  import mmio_pkg::*;

  localparam int unsigned ROM_BYTES = ROM_BYTES_DEF;
  localparam int unsigned RAM_BYTES = RAM_BYTES_DEF;
  localparam int unsigned KEY_ROWS  = KEY_ROWS_DEF;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       tape_valid;
    logic       tape_level;
  } reply_t;

  logic [7:0] rom_img  [ROM_BYTES];
  logic [7:0] ram_img  [RAM_BYTES];
  logic [7:0] vram_img [VRAM_BYTES];
  logic [7:0] key_img  [KEY_ROWS];
  logic [7:0] port_img;

  reply_t due_replies [$];
  reply_t want, got;
  int fails, compared, tape_hits;

  function automatic logic [7:0] map_read(input logic [15:0] a);
    logic [15:0] off;
    off = a - MAP_RAM_BASE;
    if (a < MAP_RAM_BASE) begin
      return (a < ROM_BYTES) ? rom_img[a] : OPEN_BUS;
    end else if (a < MAP_IO_LOW) begin
      return (off < RAM_BYTES) ? ram_img[off] : OPEN_BUS;
    end else if (a >= MAP_VRAM_BASE && a < MAP_VRAM_END) begin
      return vram_img[a[VRAM_AW-1:0]];
    end else if (a >= MAP_KEY_BASE && a < MAP_KEY_BASE + KEY_ROWS) begin
      return ~key_img[a - MAP_KEY_BASE];
    end else if (a == MAP_PORT) begin
      return port_img;
    end
    return OPEN_BUS;
  endfunction

  // updates the state copy for one accepted beat and gives the reply it should cause
  function automatic reply_t apply_access(input logic [2:0] kind, input logic [47:0] pay);
    logic [15:0] a;
    logic [7:0]  d, mask, keys;
    logic [3:0]  row;
    logic [15:0] off;
    reply_t      r;
    a    = pay[15:0];
    d    = pay[23:16];
    mask = pay[31:24];
    row  = pay[35:32];
    keys = pay[43:36];
    off  = a - MAP_RAM_BASE;
    r    = '0;
    case (kind)
      REQ_READ: begin
        r.rd_byte = map_read(a);
      end
      REQ_WRITE: begin
        if (a >= MAP_RAM_BASE && a < MAP_IO_LOW) begin
          if (off < RAM_BYTES) ram_img[off] = d;
        end else if (a >= MAP_VRAM_BASE && a < MAP_VRAM_END) begin
          vram_img[a[VRAM_AW-1:0]] = d;
        end else if (a == MAP_PORT) begin
          if (d == TAPE_HIGH_CODE) begin
            r.tape_valid = 1'b1;
            r.tape_level = 1'b1;
          end else if (d == TAPE_LOW_CODE) begin
            r.tape_valid = 1'b1;
          end
        end
      end
      REQ_ROM_LOAD: begin
        if (a < ROM_BYTES) rom_img[a] = d;
      end
      REQ_KEY_ROW: begin
        if (row < KEY_ROWS) key_img[row] = keys;
      end
      REQ_PORT_SIG: begin
        // any overlap of value and mask sets the masked bits, otherwise clears them
        if ((d & mask) != 8'h00) port_img = port_img | mask;
        else port_img = port_img & ~mask;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (rom_img[i]) rom_img[i] = ROM_FILL;
      foreach (ram_img[i]) ram_img[i] = 8'h00;
      foreach (vram_img[i]) vram_img[i] = 8'h00;
      foreach (key_img[i]) key_img[i] = 8'h00;
      port_img = 8'h00;
      due_replies.delete();
      fails     = 0;
      compared  = 0;
      tape_hits = 0;
    end else begin
      // the result of a beat taken at this edge cannot leave at the same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = reply_t'({m_axis_tdata_i[7:0], m_axis_tdata_i[8], m_axis_tdata_i[9]});
        if (due_replies.size() == 0) begin
          $error("result beat with nothing expected: %0h", m_axis_tdata_i);
          fails++;
        end else begin
          want = due_replies.pop_front();
          compared++;
          if (got.rd_byte !== want.rd_byte) begin
            $error("read_data: expected %0h, got %0h", want.rd_byte, got.rd_byte);
            fails++;
          end
          if (got.tape_valid !== want.tape_valid) begin
            $error("tape_out_valid: expected %0b, got %0b", want.tape_valid, got.tape_valid);
            fails++;
          end
          if (got.tape_level !== want.tape_level) begin
            $error("tape_out_level: expected %0b, got %0b", want.tape_level, got.tape_level);
            fails++;
          end
          if (want.tape_valid) tape_hits++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        due_replies.push_back(apply_access(s_axis_tuser_i, s_axis_tdata_i));
      end
    end
    fails_o     <= fails;
    pending_o   <= due_replies.size();
    compared_o  <= compared;
    tape_hits_o <= tape_hits;
  end

endmodule

// ===== sim/tb_top.sv =====
// testbench top for the memory map block: clock, reset, stimulus on s_axis,
// random back-pressure on m_axis and the verdict
// depends on mmio_pkg, memory_map_with_io_ports and memory_map_checker
module tb_top;
  import mmio_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1850;
  localparam int LONG_HOLD    = 300;
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        s_valid = 1'b0;
  logic [47:0] s_data  = '0;
  logic [2:0]  s_user  = '0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [15:0] m_data;

  int fails, pending, compared, tape_hits;
  int cycles = 0;
  int kind_count [8];
  int tx_mode = 0;
  int rx_mode = 0;
  bit hold_req = 1'b0;
  logic [15:0] recent_addrs [$];

  always #6 clk = ~clk;

  memory_map_with_io_ports DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  memory_map_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .fails_o         (fails),
    .pending_o       (pending),
    .compared_o      (compared),
    .tape_hits_o     (tape_hits)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // mode 0 never idles, mode 1 idles now and then, mode 2 may idle before every beat
  function automatic int draw_gap(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
    return $urandom_range(0, 12);
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic [2:0] kind, input logic [47:0] pay);
    int gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_user  <= kind;
    s_data  <= pay;
    s_valid <= 1'b1;
    do @(posedge clk); while (!s_ready);
    kind_count[kind]++;
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [2:0] kind, input logic [15:0] a,
                             input logic [7:0] d, input logic [7:0] mask,
                             input logic [3:0] row, input logic [7:0] keys);
    send_item(kind, {4'h0, keys, row, mask, d, a});
  endtask

  function automatic logic [15:0] pick_addr(input bit prefer_recent);
    int sel;
    sel = $urandom_range(0, 9);
    if ((prefer_recent || sel == 9) && recent_addrs.size() > 0)
      return recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
    case (sel)
      0:       return 16'($urandom_range(0, 16'h1fff));
      1, 2:    return MAP_RAM_BASE + 16'($urandom_range(0, 16'h0fff));
      3, 4:    return MAP_VRAM_BASE + 16'($urandom_range(0, VRAM_BYTES - 1));
      5:       return MAP_KEY_BASE + 16'($urandom_range(0, 15));
      6:       return MAP_PORT;
      7:       return MAP_IO_LOW + 16'($urandom_range(0, 16'h0fff));
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  task automatic send_random;
    logic [2:0]  kind;
    logic [15:0] a;
    logic [7:0]  d;
    int          r;
    r = $urandom_range(0, 99);
    d = 8'($urandom_range(0, 255));
    if (r < 35) begin
      kind = REQ_READ;
      a    = pick_addr($urandom_range(0, 9) < 4);
    end else if (r < 65) begin
      kind = REQ_WRITE;
      a    = pick_addr(1'b0);
      if (a == MAP_PORT) begin
        case ($urandom_range(0, 2))
          0:       d = TAPE_HIGH_CODE;
          1:       d = TAPE_LOW_CODE;
          default: d = 8'($urandom_range(0, 255));
        endcase
      end
    end else if (r < 75) begin
      kind = REQ_ROM_LOAD;
      a    = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 16'hffff))
                                         : 16'($urandom_range(0, 16'h1fff));
    end else if (r < 85) begin
      kind = REQ_KEY_ROW;
      a    = 16'($urandom_range(0, 16'hffff));
    end else if (r < 96) begin
      kind = REQ_PORT_SIG;
      a    = 16'($urandom_range(0, 16'hffff));
    end else begin
      kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      a    = 16'($urandom_range(0, 16'hffff));
    end
    if (kind == REQ_WRITE || kind == REQ_ROM_LOAD) begin
      recent_addrs.push_back(a);
      if (recent_addrs.size() > 16) void'(recent_addrs.pop_front());
    end
    send_fields(kind, a, d, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                8'($urandom_range(0, 255)));
  endtask

  task automatic send_directed;
    send_fields(REQ_READ,     16'h0000, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_ROM_LOAD, 16'h0000, 8'h5a, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_ROM_LOAD, 16'h1fff, 8'ha5, 8'h00, 4'd0, 8'h00);
    // rom offset past the end is ignored
    send_fields(REQ_ROM_LOAD, 16'hffff, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_WRITE,    16'h0000, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_READ,     16'h0000, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_READ,     16'h1fff, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_WRITE,    16'h2000, 8'hff, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_WRITE,    16'h2fff, 8'h81, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_READ,     16'h2fff, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_WRITE,    16'h43ff, 8'hee, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_READ,     16'h43ff, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_KEY_ROW,  16'h0000, 8'h00, 8'h00, 4'd0, 8'hff);
    send_fields(REQ_KEY_ROW,  16'h0000, 8'h00, 8'h00, 4'd8, 8'h01);
    send_fields(REQ_KEY_ROW,  16'h0000, 8'h00, 8'h00, 4'd15, 8'h55);
    send_fields(REQ_READ,     16'h3808, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_READ,     16'h3809, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_WRITE,    MAP_PORT, TAPE_HIGH_CODE, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_WRITE,    MAP_PORT, TAPE_LOW_CODE, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_WRITE,    MAP_PORT, 8'h55, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_PORT_SIG, 16'h0000, 8'hff, 8'hf0, 4'd0, 8'h00);
    send_fields(REQ_PORT_SIG, 16'h0000, 8'h0f, 8'h30, 4'd0, 8'h00);
    send_fields(REQ_READ,     MAP_PORT, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(REQ_SPARE_HI, 16'hffff, 8'hff, 8'hff, 4'd15, 8'hff);
    send_fields(REQ_READ,     16'hffff, 8'h00, 8'h00, 4'd0, 8'h00);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_directed();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) tx_mode = $urandom_range(0, 2);
      if (i == 600) hold_req = 1'b1;
      if (i == 1200) begin
        // let the block drain completely before going on
        s_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        @(negedge clk);
      end
      send_random();
    end
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("covered %0d reads, %0d writes, %0d rom loads, %0d key rows, %0d port updates",
             kind_count[REQ_READ], kind_count[REQ_WRITE], kind_count[REQ_ROM_LOAD],
             kind_count[REQ_KEY_ROW], kind_count[REQ_PORT_SIG]);
    $display("%0d results compared, %0d tape level beats, %0d spare kinds",
             compared, tape_hits,
             kind_count[REQ_SPARE_LO] + kind_count[REQ_SPARE_LO + 3'd1] +
             kind_count[REQ_SPARE_HI]);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side: random back-pressure, plus one long hold when asked for
  initial begin : sink
    int gap;
    int beats;
    bit held;
    beats = 0;
    held  = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (beats % 64 == 0) rx_mode = $urandom_range(0, 2);
      if (hold_req && !held) begin
        m_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held = 1'b1;
      end
      gap = draw_gap(rx_mode);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
      beats++;
      @(negedge clk);
    end
  end

endmodule

// ===== memory_map_with_io_ports.f =====
+incdir+design
design/mmio_pkg.sv
design/mmio_ram.sv
design/memory_map_with_io_ports.sv
sim/memory_map_checker.sv
sim/tb_top.sv
